FILE: sv/ash_pkg.sv
// Shared types, constants and tables of the ray versus sphere hit test.
`timescale 1ns / 1ps
package ash_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TAB_LEN = 24;
  localparam int CORDIC_RUN = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;

  localparam int ANG_W = 30;
  localparam int XY_W = 33;
  localparam int TRIG_W = 32;

  localparam logic signed [ANG_W-1:0] PI_Q24 = 30'sd52707179;
  localparam logic signed [ANG_W-1:0] NEG_PI_Q24 = -30'sd52707179;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 30'sd26353589;
  localparam logic signed [ANG_W-1:0] NEG_HALF_PI_Q24 = -30'sd26353589;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q24 = 30'sd105414357;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_PW = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW = $clog2(OQ_DEPTH);

  localparam logic signed [15:0] CENTRE_X_RST = 16'sd0;
  localparam logic signed [15:0] CENTRE_Y_RST = 16'sd0;
  localparam logic signed [15:0] CENTRE_Z_RST = -16'sd1792;
  localparam logic [14:0] RADIUS_RST = 15'd256;

  typedef enum logic [2:0] {
    CFG_CENTRE_X = 3'd0,
    CFG_CENTRE_Y = 3'd1,
    CFG_CENTRE_Z = 3'd2,
    CFG_RADIUS   = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cp;
  } trig_t;

  typedef struct packed {
    logic hit;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } result_t;

  // Arctangent of 2^-i in radians scaled by 2^24.
  function automatic logic signed [ANG_W-1:0] atan_q24(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 30'sd13176795;
      1: r = 30'sd7778716;
      2: r = 30'sd4110060;
      3: r = 30'sd2086331;
      4: r = 30'sd1047214;
      5: r = 30'sd524117;
      6: r = 30'sd262123;
      7: r = 30'sd131069;
      8: r = 30'sd65536;
      9: r = 30'sd32768;
      10: r = 30'sd16384;
      11: r = 30'sd8192;
      12: r = 30'sd4096;
      13: r = 30'sd2048;
      14: r = 30'sd1024;
      15: r = 30'sd512;
      16: r = 30'sd256;
      17: r = 30'sd128;
      18: r = 30'sd64;
      19: r = 30'sd32;
      20: r = 30'sd16;
      21: r = 30'sd8;
      22: r = 30'sd4;
      23: r = 30'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ash_front.sv
// Front end: angle folding and the two CORDIC sine/cosine pipelines.
`timescale 1ns / 1ps
module ash_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [15:0]    yaw,
  input  logic signed [13:0]    pitch,
  output logic                  in_ready,
  output logic                  out_valid,
  output ash_pkg::trig_t        out_trig,
  input  logic                  out_ready
);

  localparam int N = ash_pkg::CORDIC_RUN;
  localparam int AW = ash_pkg::ANG_W;
  localparam int XW = ash_pkg::XY_W;

  logic en;
  logic signed [AW-1:0] a_in [2];
  logic v_fold;
  logic signed [AW-1:0] fa [2];
  logic [N:0] cv;
  logic signed [XW-1:0] cx [2][N+1];
  logic signed [XW-1:0] cy [2][N+1];
  logic signed [AW-1:0] cz [2][N+1];
  logic fl [2][N+1];

  function automatic logic signed [AW-1:0] turn_fold(input logic signed [AW-1:0] a);
    if (a > ash_pkg::PI_Q24) begin
      return a - ash_pkg::TWO_PI_Q24;
    end else if (a <= ash_pkg::NEG_PI_Q24) begin
      return a + ash_pkg::TWO_PI_Q24;
    end
    return a;
  endfunction

  assign en = !(out_valid && !out_ready);
  assign in_ready = en;

  // The yaw enters negated; both angles widen to radians times 2^24.
  always_comb begin
    a_in[0] = -(AW'(yaw) <<< 12);
    a_in[1] = AW'(pitch) <<< 12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_fold <= 1'b0;
    end else if (en) begin
      v_fold <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        fa[l] <= turn_fold(a_in[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
    end else if (en) begin
      cv <= {cv[N-1:0], v_fold};
    end
  end

  // A half turn brings the angle into the CORDIC range and negates sin and cos.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        cx[l][0] <= ash_pkg::GAIN_Q30;
        cy[l][0] <= '0;
        if (fa[l] > ash_pkg::HALF_PI_Q24) begin
          cz[l][0] <= fa[l] - ash_pkg::PI_Q24;
          fl[l][0] <= 1'b1;
        end else if (fa[l] < ash_pkg::NEG_HALF_PI_Q24) begin
          cz[l][0] <= fa[l] + ash_pkg::PI_Q24;
          fl[l][0] <= 1'b1;
        end else begin
          cz[l][0] <= fa[l];
          fl[l][0] <= 1'b0;
        end
        for (int k = 0; k < N; k++) begin
          fl[l][k+1] <= fl[l][k];
          if (!cz[l][k][AW-1]) begin
            cx[l][k+1] <= cx[l][k] - (cy[l][k] >>> k);
            cy[l][k+1] <= cy[l][k] + (cx[l][k] >>> k);
            cz[l][k+1] <= cz[l][k] - ash_pkg::atan_q24(k);
          end else begin
            cx[l][k+1] <= cx[l][k] + (cy[l][k] >>> k);
            cy[l][k+1] <= cy[l][k] - (cx[l][k] >>> k);
            cz[l][k+1] <= cz[l][k] + ash_pkg::atan_q24(k);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_trig.sy <= ash_pkg::TRIG_W'(fl[0][N] ? -cy[0][N] : cy[0][N]);
      out_trig.cy <= ash_pkg::TRIG_W'(fl[0][N] ? -cx[0][N] : cx[0][N]);
      out_trig.sp <= ash_pkg::TRIG_W'(fl[1][N] ? -cy[1][N] : cy[1][N]);
      out_trig.cp <= ash_pkg::TRIG_W'(fl[1][N] ? -cx[1][N] : cx[1][N]);
    end
  end

endmodule

FILE: sv/ash_midq.sv
// Short queue that carries sine/cosine beats from the front end to the back end.
`timescale 1ns / 1ps
module ash_midq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ash_pkg::trig_t din,
  output logic           full,
  input  logic           pop,
  output ash_pkg::trig_t dout,
  output logic           empty
);

  localparam int PW = ash_pkg::MQ_PW;

  ash_pkg::trig_t mem [ash_pkg::MQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (PW+1)'(ash_pkg::MQ_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/ash_back.sv
// Back end: direction rounding, sphere test arithmetic and the result queue.
`timescale 1ns / 1ps
module ash_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  ash_pkg::trig_t       in_trig,
  output logic                 in_ready,
  input  logic signed [15:0]   centre_x,
  input  logic signed [15:0]   centre_y,
  input  logic signed [15:0]   centre_z,
  input  logic signed [32:0]   c16,
  output logic                 empty,
  input  logic                 pop,
  output logic                 hit,
  output logic signed [15:0]   dir_x,
  output logic signed [15:0]   dir_y,
  output logic signed [15:0]   dir_z
);

  localparam int PW = ash_pkg::OQ_PW;

  logic en;
  logic v1, v2, v3, v4, v5, v6;
  logic signed [63:0] px1, pz1;
  logic signed [15:0] dy1;
  logic signed [15:0] dx2, dy2, dz2;
  logic signed [31:0] mx3, my3, mz3;
  logic signed [15:0] dx3, dy3, dz3;
  logic signed [31:0] p4;
  logic signed [15:0] dx4, dy4, dz4;
  logic signed [63:0] pp5;
  logic ppos5;
  logic signed [15:0] dx5, dy5, dz5;
  logic signed [65:0] q;
  ash_pkg::result_t r6;
  ash_pkg::result_t oq_mem [ash_pkg::OQ_DEPTH];
  logic [PW-1:0] oq_wr;
  logic [PW-1:0] oq_rd;
  logic [PW:0] oq_count;
  logic oq_full;
  logic oq_push;
  logic oq_pop;

  function automatic logic signed [15:0] rnd_sat46(input logic signed [63:0] v);
    logic signed [64:0] t;
    t = {v[63], v} + (65'sd1 <<< 45);
    t = t >>> 46;
    if (t > 65'sd16384) begin
      return 16'sd16384;
    end else if (t < -65'sd16384) begin
      return -16'sd16384;
    end
    return t[15:0];
  endfunction

  function automatic logic signed [15:0] rnd_sat16(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = {v[31], v} + 33'sd32768;
    t = t >>> 16;
    if (t > 33'sd16384) begin
      return 16'sd16384;
    end else if (t < -33'sd16384) begin
      return -16'sd16384;
    end
    return t[15:0];
  endfunction

  assign oq_full = (oq_count == (PW+1)'(ash_pkg::OQ_DEPTH));
  assign empty = (oq_count == '0);
  assign en = !(v6 && oq_full);
  assign in_ready = en;
  assign oq_push = v6 && !oq_full;
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // The discriminant test compares p^2 against c scaled up to the same 2^44.
  always_comb begin
    q = {{2{pp5[63]}}, pp5} - (66'(c16) <<< 28);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= in_trig.sy * in_trig.cp;
      pz1 <= in_trig.cy * in_trig.cp;
      dy1 <= rnd_sat16(in_trig.sp);

      dx2 <= rnd_sat46(px1);
      dz2 <= rnd_sat46(-pz1);
      dy2 <= dy1;

      mx3 <= dx2 * centre_x;
      my3 <= dy2 * centre_y;
      mz3 <= dz2 * centre_z;
      dx3 <= dx2;
      dy3 <= dy2;
      dz3 <= dz2;

      p4 <= mx3 + my3 + mz3;
      dx4 <= dx3;
      dy4 <= dy3;
      dz4 <= dz3;

      pp5 <= p4 * p4;
      ppos5 <= (p4 > 32'sd0);
      dx5 <= dx4;
      dy5 <= dy4;
      dz5 <= dz4;

      r6.hit <= !q[65] && (ppos5 || c16[32]);
      r6.dx <= dx5;
      r6.dy <= dy5;
      r6.dz <= dz5;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem[oq_wr] <= r6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr <= '0;
      oq_rd <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  assign hit = oq_mem[oq_rd].hit;
  assign dir_x = oq_mem[oq_rd].dx;
  assign dir_y = oq_mem[oq_rd].dy;
  assign dir_z = oq_mem[oq_rd].dz;

`ifndef NO_ASSERTIONS
  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= (PW+1)'(ash_pkg::OQ_DEPTH))
    else $error("result queue count beyond its depth");

  a_oq_fill: assert property (@(posedge clk) disable iff (rst)
    (oq_push && !oq_pop) |=> (oq_count == $past(oq_count) + 1'b1))
    else $error("finished result beat not taken into the result queue");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en) |=> ($stable(r6) && v6))
    else $error("last pipeline stage changed while stalled");
`endif

endmodule

FILE: sv/aim_ray_sphere_hit_test.sv
// Top level: configuration registers, front end, queue and back end of the hit test.
// Throughput: one beat per cycle while the result queue has room; the CORDIC and
// multiply pipelines are fully staged.
// full rises only when the result queue, the middle queue and both pipelines back up.
// Synchronous active-high reset empties every queue and pipeline and loads the
// register defaults: centre (0, 0, -7.0) and radius 1.0.
`timescale 1ns / 1ps
module aim_ray_sphere_hit_test (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   yaw_angle,
  input  logic signed [13:0]   pitch_angle,
  output logic                 empty,
  input  logic                 pop,
  output logic                 hit,
  output logic signed [15:0]   dir_x,
  output logic signed [15:0]   dir_y,
  output logic signed [15:0]   dir_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  logic signed [15:0] centre_x;
  logic signed [15:0] centre_y;
  logic signed [15:0] centre_z;
  logic [14:0] radius;
  logic signed [31:0] sq_x, sq_y, sq_z, sq_r;
  logic signed [32:0] c16;

  logic front_ready;
  logic front_valid;
  ash_pkg::trig_t front_trig;
  logic mq_full;
  logic mq_empty;
  ash_pkg::trig_t mq_trig;
  logic back_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x <= ash_pkg::CENTRE_X_RST;
      centre_y <= ash_pkg::CENTRE_Y_RST;
      centre_z <= ash_pkg::CENTRE_Z_RST;
      radius <= ash_pkg::RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ash_pkg::CFG_CENTRE_X: centre_x <= cfg_data;
        ash_pkg::CFG_CENTRE_Y: centre_y <= cfg_data;
        ash_pkg::CFG_CENTRE_Z: centre_z <= cfg_data;
        ash_pkg::CFG_RADIUS: radius <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // |C|^2 - r^2: the squares are registered first, then their sum and difference.
  always_ff @(posedge clk) begin
    sq_x <= centre_x * centre_x;
    sq_y <= centre_y * centre_y;
    sq_z <= centre_z * centre_z;
    sq_r <= $signed({1'b0, radius}) * $signed({1'b0, radius});
    c16 <= 33'(sq_x) + 33'(sq_y) + 33'(sq_z) - 33'(sq_r);
  end

  assign full = !front_ready;

  ash_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push && front_ready),
    .yaw       (yaw_angle),
    .pitch     (pitch_angle),
    .in_ready  (front_ready),
    .out_valid (front_valid),
    .out_trig  (front_trig),
    .out_ready (!mq_full)
  );

  ash_midq u_midq (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .din   (front_trig),
    .full  (mq_full),
    .pop   (back_ready),
    .dout  (mq_trig),
    .empty (mq_empty)
  );

  ash_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!mq_empty),
    .in_trig  (mq_trig),
    .in_ready (back_ready),
    .centre_x (centre_x),
    .centre_y (centre_y),
    .centre_z (centre_z),
    .c16      (c16),
    .empty    (empty),
    .pop      (pop),
    .hit      (hit),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z)
  );

endmodule

FILE: bench/aim_ray_sphere_hit_test_test.sv
// Testbench of the view-ray versus sphere hit test: predicts each result and compares it.
`timescale 1ns / 1ps
module aim_ray_sphere_hit_test_test;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [13:0] pitch;
  } angles_t;

  typedef struct {
    logic hit;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } aim_t;

  localparam int LATENCY = ash_pkg::CORDIC_STAGES + 10;
  localparam int STALL_LIMIT = 20000;
  localparam longint ATAN_TAB [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] yaw_angle = '0;
  logic signed [13:0] pitch_angle = '0;
  logic empty;
  logic pop = 1'b0;
  logic hit;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  angles_t pending_angles[$];
  aim_t expected_aims[$];
  longint cx, cy, cz, rad;
  int mismatches = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit random_pop = 1'b1;

  aim_ray_sphere_hit_test u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .yaw_angle(yaw_angle), .pitch_angle(pitch_angle),
    .empty(empty), .pop(pop), .hit(hit),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_dir(longint v, int s);
    longint r;
    r = floor_shift(v + (longint'(1) << (s - 1)), s);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // Sine and cosine of an angle in radians * 2^24, both scaled by 2^30.
  task automatic cordic_sincos(input longint a, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    int n;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    n = (ash_pkg::CORDIC_STAGES > 24) ? 24 : ash_pkg::CORDIC_STAGES;
    while (a > 52707179) a -= 105414357;
    while (a <= -52707179) a += 105414357;
    if (a > 26353589) begin
      a -= 52707179;
      flip = 1'b1;
    end else if (a < -26353589) begin
      a += 52707179;
      flip = 1'b1;
    end
    z = a;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic predict_aim(input angles_t a, output aim_t r);
    longint sy, cyw, sp, cp, dx, dy, dz, p, c16, q;
    cordic_sincos(-longint'(a.yaw) * 4096, sy, cyw);
    cordic_sincos(longint'(a.pitch) * 4096, sp, cp);
    dx = round_dir(sy * cp, 46);
    dy = round_dir(sp, 16);
    dz = round_dir(-(cyw * cp), 46);
    p = dx * cx + dy * cy + dz * cz;
    c16 = cx * cx + cy * cy + cz * cz - rad * rad;
    q = p * p - c16 * (longint'(1) << 28);
    r.hit = (q >= 0) && (p > 0 || c16 < 0);
    r.dx = dx[15:0];
    r.dy = dy[15:0];
    r.dz = dz[15:0];
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 50) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Handshake state captured at the rising edge for the driver.
  bit full_at_edge = 1'b0;
  always @(posedge clk) full_at_edge <= full;

  // Driver: offers queued angle pairs with random gaps; prediction happens on acceptance.
  // An offered beat is held unchanged until it is taken.
  int drive_gap = 0;
  bit drive_gaps_on = 1'b1;
  always @(negedge clk) begin
    aim_t e;
    bit accepted;
    if (!rst) begin
      accepted = push && !full_at_edge;
      if (accepted) begin
        predict_aim(pending_angles.pop_front(), e);
        expected_aims.push_back(e);
      end
      if (push && !accepted) begin
        push <= 1'b1;
      end else if (drive_gap > 0) begin
        drive_gap <= drive_gap - 1;
        push <= 1'b0;
      end else if (pending_angles.size() > 0) begin
        push <= 1'b1;
        yaw_angle <= pending_angles[0].yaw;
        pitch_angle <= pending_angles[0].pitch;
        if (drive_gaps_on) drive_gap <= gap_len();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: checks each popped beat against the oldest prediction.
  always @(posedge clk) begin
    aim_t e;
    if (!rst && pop && !empty) begin
      if (expected_aims.size() == 0) begin
        $display("%0t: unexpected result hit=%0b dir=(%0d,%0d,%0d)",
                 $time, hit, dir_x, dir_y, dir_z);
        mismatches++;
      end else begin
        e = expected_aims.pop_front();
        results_seen++;
        if (e.hit) hits_seen++;
        if (hit !== e.hit || dir_x !== e.dx || dir_y !== e.dy || dir_z !== e.dz) begin
          $display("%0t: expected hit=%0b dir=(%0d,%0d,%0d) got hit=%0b dir=(%0d,%0d,%0d)",
                   $time, e.hit, e.dx, e.dy, e.dz, hit, dir_x, dir_y, dir_z);
          mismatches++;
        end
      end
    end
  end

  // Receiver pacing, with a long hold-off on request.
  int pop_gap = 0;
  int hold_count = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      pop <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (random_pop) pop_gap <= gap_len();
    end
  end

  // Watchdog on cycles without any accepted push, pop or register write.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input ash_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      ash_pkg::CFG_CENTRE_X: cx = longint'($signed(val));
      ash_pkg::CFG_CENTRE_Y: cy = longint'($signed(val));
      ash_pkg::CFG_CENTRE_Z: cz = longint'($signed(val));
      ash_pkg::CFG_RADIUS:   rad = longint'(val[14:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_angles.size() > 0 || expected_aims.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic add_angles(input int y, input int p);
    angles_t a;
    a.yaw = 16'(y);
    a.pitch = 14'(p);
    pending_angles.push_back(a);
  endtask

  // Random angles; mostly in range and aimed near the sphere, sometimes any pattern.
  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: add_angles($urandom, $urandom);
        1: add_angles($urandom_range(0, 51472) - 25736, $urandom_range(0, 12868) - 6434);
        default: add_angles($urandom_range(0, 1200) - 600, $urandom_range(0, 1200) - 600);
      endcase
    end
  endtask

  initial begin
    cx = 0;
    cy = 0;
    cz = -1792;
    rad = 256;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, half-turn and whole-turn folding, straight ahead.
    add_angles(0, 0);
    add_angles(16'sh7fff, 14'sh1fff);
    add_angles(16'sh8000, 14'sh2000);
    add_angles(25736, 6434);
    add_angles(-25736, -6434);
    add_angles(12868, 0);
    add_angles(-12868, 0);
    add_angles(6434, 0);
    add_angles(0, 6434);
    add_angles(0, -6434);
    add_angles(100, -100);
    add_angles(16'shffff, 14'sh3fff);
    drain();

    // Point sphere on the axis, and the point at the origin.
    write_reg(ash_pkg::CFG_RADIUS, 16'd0);
    add_angles(0, 0);
    add_angles(1, 0);
    add_angles(12868, 0);
    drain();
    write_reg(ash_pkg::CFG_CENTRE_Z, 16'd0);
    add_angles(0, 0);
    add_angles(300, 300);
    drain();

    // Extreme register settings.
    write_reg(ash_pkg::CFG_CENTRE_X, 16'h7fff);
    write_reg(ash_pkg::CFG_CENTRE_Y, 16'h8000);
    write_reg(ash_pkg::CFG_CENTRE_Z, 16'h8000);
    write_reg(ash_pkg::CFG_RADIUS, 16'h7fff);
    add_random(100);
    drain();

    // Long receiver hold-off while the sender keeps offering beats.
    hold_off = 1'b1;
    drive_gaps_on = 1'b0;
    write_reg(ash_pkg::CFG_CENTRE_X, 16'd0);
    write_reg(ash_pkg::CFG_CENTRE_Y, 16'd0);
    write_reg(ash_pkg::CFG_CENTRE_Z, 16'hf900);
    write_reg(ash_pkg::CFG_RADIUS, 16'd256);
    add_random(60);
    while (hold_count < 200) @(posedge clk);
    hold_off = 1'b0;
    drive_gaps_on = 1'b1;
    drain();

    // Random settings and random angles.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(ash_pkg::CFG_CENTRE_X,
                16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1024) - 512));
      write_reg(ash_pkg::CFG_CENTRE_Y,
                16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1024) - 512));
      write_reg(ash_pkg::CFG_CENTRE_Z,
                16'($urandom_range(0, 1) ? $urandom : -$urandom_range(256, 3000)));
      write_reg(ash_pkg::CFG_RADIUS,
                16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1024)));
      random_pop = (ph != 4);
      add_random(100);
      drain();
    end

    $display("covered %0d results, %0d hits, extremes of registers and angles",
             results_seen, hits_seen);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
